FILE: hdl/assert_macros.svh
// Assertion macros shared by the receiver RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication property
`define URX_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition this cycle, property in the next cycle
`define URX_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: hdl/urx_pkg.sv
// Shared types, constants and helpers for the 8N1 receiver with byte FIFO.
// No dependencies.
package urx_pkg;

   localparam int DEPTH   = 128;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int FILL_W  = 7;
   localparam int PER_W   = 16;
   localparam int BIT_W   = 3;
   localparam int BYTE_W  = 8;
   localparam int IN_W    = 8;
   localparam int OUT_W   = 24;
   localparam int CSR_A_W = 3;
   localparam int CSR_D_W = 32;

   localparam logic [CSR_A_W-1:0] CSR_BIT_PERIOD = 3'd0;
   localparam logic [PER_W-1:0]   BIT_PERIOD_RST = 16'd2604;

   localparam logic [1:0] DROP_NONE = 2'd0;
   localparam logic [1:0] DROP_STOP = 2'd1;
   localparam logic [1:0] DROP_FULL = 2'd2;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_START = 4'b0010,
      PH_DATA  = 4'b0100,
      PH_STOP  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic              done;
      logic              stop_ok;
      logic [BYTE_W-1:0] data;
   } frame_type;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_fill(input logic [PTR_W-1:0] w,
                                                 input logic [PTR_W-1:0] r);
      logic [PTR_W:0] diff;
      diff = {1'b0, w} - {1'b0, r};
      if (w < r) begin
         diff = diff + (PTR_W+1)'(DEPTH);
      end
      return diff[PTR_W-1:0];
   endfunction

endpackage

FILE: hdl/urx_ram.sv
// Generic single-write, single-read RAM with registered, enabled read port.
// No dependencies.
module urx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/urx_deframer.sv
// 8N1 deframer: start detect, start recheck, data and stop sampling.
// Depends on urx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module urx_deframer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    line,
   input  logic [urx_pkg::PER_W-1:0] bit_period,
   output urx_pkg::frame_type      frm
);
   import urx_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [PER_W-1:0]   tick_ff, tick_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [BYTE_W-1:0]  shift_ff, shift_in;
   logic               prev_ff;
   logic [PER_W-1:0]   wait_sel, wait_eff, tick_next;
   logic               tick_done;

   assign wait_sel  = (phase_ff == PH_START) ? {1'b0, bit_period[PER_W-1:1]} : bit_period;
   assign wait_eff  = (wait_sel == '0) ? PER_W'(1) : wait_sel;
   assign tick_next = tick_ff + PER_W'(1);
   assign tick_done = (tick_next >= wait_eff);

   always_comb begin
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      frm.done    = 1'b0;
      frm.stop_ok = line;
      frm.data    = shift_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (prev_ff && !line) begin
               phase_in = PH_START;
               tick_in  = '0;
            end
         end
         PH_START: begin
            tick_in = tick_done ? '0 : tick_next;
            if (tick_done) begin
               if (!line) begin
                  phase_in = PH_DATA;
                  bit_in   = '0;
                  shift_in = '0;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_DATA: begin
            tick_in = tick_done ? '0 : tick_next;
            if (tick_done) begin
               shift_in = shift_ff | (BYTE_W'(line) << bit_ff);
               if (bit_ff == BIT_W'(BYTE_W - 1)) begin
                  bit_in   = '0;
                  phase_in = PH_STOP;
               end else begin
                  bit_in = bit_ff + BIT_W'(1);
               end
            end
         end
         PH_STOP: begin
            tick_in = tick_done ? '0 : tick_next;
            if (tick_done) begin
               frm.done = en;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         prev_ff  <= 1'b1;
      end else if (en) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         prev_ff  <= line;
      end
   end

   `URX_ASSERT_NEXT(a_start_arms, en && phase_ff == PH_IDLE && prev_ff && !line,
      phase_ff == PH_START && tick_ff == '0, "falling edge in idle did not arm start check")
   `URX_ASSERT(a_bit_idle, phase_ff != PH_DATA |-> bit_ff == '0,
      "bit index nonzero outside data phase")
   `URX_ASSERT(a_phase_onehot, $onehot(phase_ff), "deframer phase not one-hot")

endmodule

FILE: hdl/uart_receiver_with_fifo_unit.sv
// UART 8N1 receiver with byte FIFO, top level.
// Depends on urx_pkg, urx_deframer, urx_ram and assert_macros.svh.
//
// Usage:
//   req channel: one transfer per serial clock tick, carrying the sampled line level
//     and a pop request. A new transfer is taken every cycle while rsp is not stalled.
//   rsp channel: exactly one transfer per req transfer, in order: popped byte,
//     pop valid, FIFO fill count after the tick, and a drop code (stop bit or full).
//   csr port: bit_period at address 0 (ticks per serial bit); write only when idle.
// Path: a req transfer goes through the input register, then the result register with
//   the FIFO RAM's registered read. Throughput: one per cycle when rsp does not stall.
// The FIFO is a 128-entry RAM and holds up to 127 bytes; a frame arriving when full
//   is dropped and flagged.
// Reset: deframer idle, FIFO empty, bit_period back to 2604; no RAM clearing.
// When rsp stalls the result stage holds, one more req transfer is absorbed by the
//   input register, then req_tready falls until rsp drains.
`include "assert_macros.svh"

module uart_receiver_with_fifo_unit (
   input  logic                          clock,
   input  logic                          reset,
   // req_tdata: [0] line_level, [1] pop_request, [7:2] zero
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [urx_pkg::IN_W-1:0]      req_tdata,
   // rsp_tdata: [7:0] rd_byte, [8] rd_valid, [15:9] fill_count, [17:16] drop_flag,
   //            [23:18] zero
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [urx_pkg::OUT_W-1:0]     rsp_tdata,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [urx_pkg::CSR_A_W-1:0]   csr_paddr,
   input  logic [urx_pkg::CSR_D_W-1:0]   csr_pwdata,
   output logic [urx_pkg::CSR_D_W-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import urx_pkg::*;

   logic [PER_W-1:0]  bit_period_ff;
   logic              s0_valid_ff, s0_line_ff, s0_pop_ff;
   logic              s1_valid_ff, s1_rdv_ff;
   logic [FILL_W-1:0] s1_fill_ff, s1_fill_in;
   logic [1:0]        s1_drop_ff, s1_drop_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic              adv, proc, pop_ok, full, ram_wen, ram_ren;
   logic [BYTE_W-1:0] ram_rdata;
   frame_type         frm;

   // csr
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_A_W-1:2] == CSR_BIT_PERIOD[CSR_A_W-1:2])
                       ? CSR_D_W'(bit_period_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff <= BIT_PERIOD_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[CSR_A_W-1:2] == CSR_BIT_PERIOD[CSR_A_W-1:2]) begin
         bit_period_ff <= csr_pwdata[PER_W-1:0];
      end
   end

   // flow control
   assign adv        = !s1_valid_ff || rsp_tready;
   assign proc       = s0_valid_ff && adv;
   assign req_tready = !s0_valid_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s0_line_ff <= req_tdata[0];
         s0_pop_ff  <= req_tdata[1];
      end
   end

   urx_deframer u_deframer (
      .clock      (clock),
      .reset      (reset),
      .en         (proc),
      .line       (s0_line_ff),
      .bit_period (bit_period_ff),
      .frm        (frm)
   );

   // FIFO pointers, both sides use the pointers from the start of the tick
   assign pop_ok  = s0_pop_ff && (wr_ptr_ff != rd_ptr_ff);
   assign wr_next = ptr_inc(wr_ptr_ff);
   assign full    = (wr_next == rd_ptr_ff);
   assign ram_ren = proc && pop_ok;
   assign ram_wen = frm.done && frm.stop_ok && !full;

   always_comb begin
      rd_ptr_in  = pop_ok ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      wr_ptr_in  = ram_wen ? wr_next : wr_ptr_ff;
      s1_drop_in = DROP_NONE;
      if (frm.done) begin
         if (!frm.stop_ok) begin
            s1_drop_in = DROP_STOP;
         end else if (full) begin
            s1_drop_in = DROP_FULL;
         end
      end
      s1_fill_in = FILL_W'(ptr_fill(wr_ptr_in, rd_ptr_in));
   end

   urx_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wen),
      .wr_addr (wr_ptr_ff),
      .wr_data (frm.data),
      .rd_en   (ram_ren),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (proc) begin
            wr_ptr_ff <= wr_ptr_in;
            rd_ptr_ff <= rd_ptr_in;
         end
         if (adv) begin
            s1_valid_ff <= s0_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         s1_rdv_ff  <= pop_ok;
         s1_fill_ff <= s1_fill_in;
         s1_drop_ff <= s1_drop_in;
      end
   end

   assign rsp_tvalid = s1_valid_ff;
   assign rsp_tdata  = {6'b0, s1_drop_ff, s1_fill_ff, s1_rdv_ff,
                        s1_rdv_ff ? ram_rdata : BYTE_W'(0)};

   `URX_ASSERT(a_no_overwrite, ram_wen |-> wr_next != rd_ptr_ff,
      "FIFO write while full")
   `URX_ASSERT(a_drop_no_write, s1_drop_in != DROP_NONE |-> !ram_wen,
      "dropped frame written to FIFO")
   `URX_ASSERT_NEXT(a_pop_result, proc && pop_ok, s1_valid_ff && s1_rdv_ff,
      "accepted pop not reflected in result stage")

endmodule
